/* src/ssid_pkg.sv */
package ssid_pkg;

    // Store depth and derived widths
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int VAL_W = 32;

    // Operation kinds on the input tuser
    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_DEL_MAX = 2'd1;
    localparam logic [1:0] KIND_DEL_MIN = 2'd2;
    localparam logic [1:0] KIND_DEL_MID = 2'd3;

    // Result status codes on the output tuser
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_DUP   = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    // Command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CMD_HOLD = 2'd0,
        CMD_CMP  = 2'd1,
        CMD_INS  = 2'd2,
        CMD_DEL  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                     cmd;
        logic signed [VAL_W-1:0]  value;
    } t_cell_ctl;

endpackage

/* src/ssid_cell.sv */
module ssid_cell (
    input  logic                                i_clk,
    input  ssid_pkg::t_cell_ctl                 i_ctl,
    input  logic                                i_occ,       // cell holds a live value
    input  logic                                i_del_sel,   // cell at or after delete index
    input  logic                                i_left_gt,
    input  logic signed [ssid_pkg::VAL_W-1:0]   i_left_val,
    input  logic signed [ssid_pkg::VAL_W-1:0]   i_right_val,
    output logic                                o_gt,
    output logic                                o_eq,
    output logic signed [ssid_pkg::VAL_W-1:0]   o_val
);

    logic signed [ssid_pkg::VAL_W-1:0] r_val;
    logic                              r_gt;
    logic                              r_eq;

    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            ssid_pkg::CMD_CMP: begin
                r_gt <= i_occ && (r_val > i_ctl.value);
                r_eq <= i_occ && (r_val == i_ctl.value);
            end
            ssid_pkg::CMD_INS: begin
                // larger values stay; the first non-larger cell takes the new value,
                // the rest shift one place toward the small end
                if (!r_gt) begin
                    r_val <= i_left_gt ? i_ctl.value : i_left_val;
                end
            end
            ssid_pkg::CMD_DEL: begin
                if (i_del_sel) begin
                    r_val <= i_right_val;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_gt  = r_gt;
    assign o_eq  = r_eq;
    assign o_val = r_val;

endmodule

/* src/sorted_set_insert_delete.sv */
// Sorted set store, descending order, built as a chain of compare/shift cells.
// An insert passes the idle, compare and act states (compare, then shift); a delete
// goes straight from idle to act. A new request is taken only in idle, so one request
// is finished before the next is accepted; a stalled output holds act.
// Reset: synchronous active-low; clears count, sequencer and output valid.
// Cell contents are not cleared; only cells below the count are ever used.
module sorted_set_insert_delete (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic [1:0]  i_s_tuser,   // [1:0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [4:0] count, [36:5] removed_value, [39:37] zero
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    localparam int DEPTH = ssid_pkg::DEPTH;
    localparam int CNT_W = ssid_pkg::CNT_W;
    localparam int IDX_W = ssid_pkg::IDX_W;
    localparam int VAL_W = ssid_pkg::VAL_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_ACT  = 3'b100
    } t_state;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [1:0]                r_kind;
    logic signed [VAL_W-1:0]   r_value;
    logic                      r_out_valid, n_out_valid;
    logic [1:0]                r_status, n_status;
    logic signed [VAL_W-1:0]   r_removed, n_removed;

    ssid_pkg::t_cell_ctl       w_ctl;
    logic [DEPTH-1:0]          w_gt;
    logic [DEPTH-1:0]          w_eq;
    logic signed [VAL_W-1:0]   w_val [DEPTH];
    logic [IDX_W-1:0]          w_idx;
    logic                      w_out_free;
    logic                      w_in_xfer;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    // delete index: 0 for largest, count-1 for smallest, count/2 for middle
    always_comb begin
        case (r_kind)
            ssid_pkg::KIND_DEL_MAX: w_idx = '0;
            ssid_pkg::KIND_DEL_MIN: w_idx = IDX_W'(r_count - CNT_W'(1));
            ssid_pkg::KIND_DEL_MID: w_idx = IDX_W'(r_count >> 1);
            default:                w_idx = '0;
        endcase
    end

    // Sequencer: compare broadcast for an insert, then insert/delete shift and result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_m_tready;
        n_status    = r_status;
        n_removed   = r_removed;
        w_ctl.cmd   = ssid_pkg::CMD_HOLD;
        w_ctl.value = r_value;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = (i_s_tuser == ssid_pkg::KIND_INSERT) ? ST_CMP : ST_ACT;
                end
            end
            ST_CMP: begin
                w_ctl.cmd = ssid_pkg::CMD_CMP;
                n_state   = ST_ACT;
            end
            ST_ACT: begin
                if (w_out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_removed   = '0;
                    n_status    = ssid_pkg::STAT_DONE;
                    if (r_kind == ssid_pkg::KIND_INSERT) begin
                        if (|w_eq) begin
                            n_status = ssid_pkg::STAT_DUP;
                        end else if (r_count == CNT_W'(DEPTH)) begin
                            n_status = ssid_pkg::STAT_FULL;
                        end else begin
                            w_ctl.cmd = ssid_pkg::CMD_INS;
                            n_count   = r_count + CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        n_status = ssid_pkg::STAT_EMPTY;
                    end else begin
                        w_ctl.cmd = ssid_pkg::CMD_DEL;
                        n_removed = w_val[w_idx];
                        n_count   = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_kind  <= i_s_tuser;
            r_value <= i_s_tdata;
        end
        r_status  <= n_status;
        r_removed <= n_removed;
    end

    // Cell chain: index 0 holds the largest value
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                    w_left_gt;
        logic signed [VAL_W-1:0] w_left_val;
        logic signed [VAL_W-1:0] w_right_val;

        if (g == 0) begin : g_head
            assign w_left_gt  = 1'b1;
            assign w_left_val = r_value;
        end else begin : g_body
            assign w_left_gt  = w_gt[g-1];
            assign w_left_val = w_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_val = w_val[g];
        end else begin : g_mid
            assign w_right_val = w_val[g+1];
        end

        ssid_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (CNT_W'(g) < r_count),
            .i_del_sel   (CNT_W'(g) >= CNT_W'(w_idx)),
            .i_left_gt   (w_left_gt),
            .i_left_val  (w_left_val),
            .i_right_val (w_right_val),
            .o_gt        (w_gt[g]),
            .o_eq        (w_eq[g]),
            .o_val       (w_val[g])
        );
    end

    // Result register: count (low 5 bits), removed value, status
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {3'b000, r_removed, 5'(r_count)};

endmodule
